>>> hw/rtl/amge_pkg.sv
package amge_pkg;

    localparam int MaxVertices = 64;
    localparam int VtxBits     = 6;
    localparam int CntBits     = 7;
    localparam int WeightBits  = 16;
    localparam int AddrBits    = 2 * VtxBits;
    localparam int Depth       = MaxVertices * MaxVertices;
    localparam int EdgeBits    = 12;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_OUTDEG = 3'd3,
        CMD_INDEG  = 3'd4,
        CMD_CYCLE  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNCHANGED = 2'd1,
        ST_INVALID   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_EDGE_RD,
        S_EDGE_WAIT,
        S_EDGE_ACT,
        S_DEG_RD,
        S_DEG_WAIT,
        S_ROOT,
        S_WALK,
        S_WALK_RD,
        S_WALK_ACT,
        S_RESULT
    } fsm_t;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [VtxBits-1:0]    src_vertex;
        logic [VtxBits-1:0]    dst_vertex;
        logic [WeightBits-1:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [WeightBits-1:0] weight_read;
        logic [CntBits-1:0]    degree_count;
        logic [EdgeBits-1:0]   edge_total;
        logic                  cycle_found;
    } out_item_t;

    typedef struct packed {
        logic                  we;
        logic [AddrBits-1:0]   addr;
        logic [WeightBits-1:0] wdata;
    } mem_req_t;

endpackage

>>> hw/rtl/amge_matrix.sv
module amge_matrix
(
    input  logic                            clk,
    input  amge_pkg::mem_req_t              req,
    output logic [amge_pkg::WeightBits-1:0] rdata
);

    import amge_pkg::*;

    logic [WeightBits-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

>>> hw/rtl/amge_seq.sv
module amge_seq
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [6:0]                      nv,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  amge_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output amge_pkg::out_item_t             out_item,
    output amge_pkg::mem_req_t              req,
    input  logic [amge_pkg::WeightBits-1:0] rdata
);

    import amge_pkg::*;

    fsm_t                  state_reg, state_next;
    in_item_t              item_reg, item_next;
    out_item_t             res_reg, res_next;
    logic [AddrBits:0]     clr_reg, clr_next;
    logic [EdgeBits-1:0]   edges_reg, edges_next;
    logic [CntBits-1:0]    idx_reg, idx_next;
    logic [CntBits-1:0]    deg_reg, deg_next;
    logic [MaxVertices-1:0] vis_reg, vis_next;
    logic [CntBits-1:0]    sp_reg, sp_next;
    logic [CntBits-1:0]    root_reg, root_next;
    logic [VtxBits-1:0]    cur_v_reg, cur_v_next;
    logic [VtxBits-1:0]    cur_p_reg, cur_p_next;
    logic [CntBits-1:0]    cur_w_reg, cur_w_next;
    logic                  found_reg, found_next;

    logic [3*VtxBits:0]    stk [MaxVertices];
    logic [3*VtxBits:0]    stk_rd;
    logic                  stk_we;
    logic [VtxBits-1:0]    stk_waddr;
    logic [3*VtxBits:0]    stk_wdata;
    logic                  stk_re;
    logic [VtxBits-1:0]    stk_raddr;

    logic [CntBits-1:0]    n;
    logic                  sv, dv;
    logic [VtxBits-1:0]    s_v, d_v, wv;

    assign n   = (nv > CntBits'(MaxVertices)) ? CntBits'(MaxVertices) : nv;
    assign s_v = item_reg.src_vertex;
    assign d_v = item_reg.dst_vertex;
    assign sv  = {1'b0, s_v} < n;
    assign dv  = {1'b0, d_v} < n;
    assign wv  = cur_w_reg[VtxBits-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);
    assign out_item  = res_reg;

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd <= stk[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            edges_reg <= '0;
            sp_reg    <= '0;
            vis_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            edges_reg <= edges_next;
            sp_reg    <= sp_next;
            vis_reg   <= vis_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        idx_reg   <= idx_next;
        deg_reg   <= deg_next;
        root_reg  <= root_next;
        cur_v_reg <= cur_v_next;
        cur_p_reg <= cur_p_next;
        cur_w_reg <= cur_w_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        clr_next   = clr_reg;
        edges_next = edges_reg;
        idx_next   = idx_reg;
        deg_next   = deg_reg;
        vis_next   = vis_reg;
        sp_next    = sp_reg;
        root_next  = root_reg;
        cur_v_next = cur_v_reg;
        cur_p_next = cur_p_reg;
        cur_w_next = cur_w_reg;
        found_next = found_reg;
        req        = '{we: 1'b0, addr: {s_v, d_v}, wdata: '0};
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[VtxBits-1:0];
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = sp_reg[VtxBits-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                req.we   = 1'b1;
                req.addr = clr_reg[AddrBits-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg[AddrBits-1:0] == {AddrBits{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    res_next  = '0;
                    idx_next  = '0;
                    deg_next  = '0;
                    case (in_item.cmd)
                        CMD_INSERT, CMD_REMOVE, CMD_READ: state_next = S_EDGE_RD;
                        CMD_OUTDEG, CMD_INDEG:            state_next = S_DEG_RD;
                        CMD_CYCLE:
                        begin
                            vis_next   = '0;
                            sp_next    = '0;
                            root_next  = '0;
                            found_next = 1'b0;
                            state_next = S_ROOT;
                        end
                        default:
                        begin
                            res_next.status = ST_INVALID;
                            state_next      = S_RESULT;
                        end
                    endcase
                end
            end
            S_EDGE_RD:
            begin
                state_next = S_EDGE_WAIT;
            end
            S_EDGE_WAIT:
            begin
                state_next = S_EDGE_ACT;
            end
            S_EDGE_ACT:
            begin
                state_next = S_RESULT;
                case (item_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (!sv || !dv || s_v == d_v || item_reg.edge_weight == '0)
                        begin
                            res_next.status = ST_INVALID;
                        end
                        else if (rdata != '0)
                        begin
                            res_next.status = ST_UNCHANGED;
                        end
                        else
                        begin
                            req.we     = 1'b1;
                            req.wdata  = item_reg.edge_weight;
                            edges_next = edges_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!sv || !dv)
                        begin
                            res_next.status = ST_INVALID;
                        end
                        else if (rdata == '0)
                        begin
                            res_next.status = ST_UNCHANGED;
                        end
                        else
                        begin
                            req.we     = 1'b1;
                            edges_next = edges_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!sv || !dv)
                        begin
                            res_next.status = ST_INVALID;
                        end
                        else
                        begin
                            res_next.weight_read = rdata;
                        end
                    end
                endcase
            end
            S_DEG_RD:
            begin
                if ((item_reg.cmd == CMD_OUTDEG) ? !sv : !dv)
                begin
                    res_next.status = ST_INVALID;
                    state_next      = S_RESULT;
                end
                else if (idx_reg >= n)
                begin
                    state_next = S_DEG_WAIT;
                end
                else
                begin
                    req.addr   = (item_reg.cmd == CMD_OUTDEG)
                                 ? {s_v, idx_reg[VtxBits-1:0]}
                                 : {idx_reg[VtxBits-1:0], d_v};
                    state_next = S_DEG_WAIT;
                end
            end
            S_DEG_WAIT:
            begin
                if (idx_reg >= n)
                begin
                    res_next.degree_count = deg_reg;
                    state_next            = S_RESULT;
                end
                else
                begin
                    if (rdata != '0)
                    begin
                        deg_next = deg_reg + 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DEG_RD;
                end
            end
            S_ROOT:
            begin
                if (found_reg || root_reg >= n)
                begin
                    res_next.cycle_found = found_reg;
                    sp_next              = '0;
                    state_next           = S_RESULT;
                end
                else if (vis_reg[root_reg[VtxBits-1:0]])
                begin
                    root_next = root_reg + 1'b1;
                end
                else
                begin
                    cur_v_next = root_reg[VtxBits-1:0];
                    cur_p_next = root_reg[VtxBits-1:0];
                    cur_w_next = '0;
                    vis_next[root_reg[VtxBits-1:0]] = 1'b1;
                    sp_next    = CntBits'(1);
                    root_next  = root_reg + 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (cur_w_reg >= n)
                begin
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == CntBits'(1))
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        stk_raddr  = VtxBits'(sp_reg - CntBits'(2));
                        state_next = S_WALK_ACT;
                        cur_w_next = '1;
                    end
                end
                else
                begin
                    req.addr   = {cur_v_reg, wv};
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                req.addr   = {cur_v_reg, wv};
                state_next = S_WALK_ACT;
            end
            S_WALK_ACT:
            begin
                state_next = S_WALK;
                if (cur_w_reg == '1)
                begin
                    {cur_v_next, cur_p_next, cur_w_next} = stk_rd;
                end
                else if (rdata != '0 && !vis_reg[wv])
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = VtxBits'(sp_reg - 1'b1);
                    stk_wdata  = {cur_v_reg, cur_p_reg, cur_w_reg + 1'b1};
                    vis_next[wv] = 1'b1;
                    cur_p_next = cur_v_reg;
                    cur_v_next = wv;
                    cur_w_next = '0;
                    sp_next    = sp_reg + 1'b1;
                end
                else if (rdata != '0 && wv != cur_p_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_ROOT;
                end
                else
                begin
                    cur_w_next = cur_w_reg + 1'b1;
                end
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_next == S_RESULT && state_reg != S_RESULT)
        begin
            res_next.edge_total = edges_next;
        end
    end

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CntBits'(MaxVertices))
        else $error("stack overflow");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.we && state_reg != S_CLEAR) |-> state_reg == S_EDGE_ACT)
        else $error("stray matrix write");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(res_reg))
        else $error("result changed while stalled");
`endif

endmodule

>>> hw/rtl/adjacency_matrix_graph_engine_core.sv
// insert/remove/read make one matrix read and at most one write; degree reads one entry per vertex
// cycle check is a depth-first walk, one matrix read per step
// one command at a time; the single matrix read port sets the rate
// after reset a clearing pass zeroes all 4096 matrix entries, no commands taken
// num_vertices resets to 64
module adjacency_matrix_graph_engine_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  amge_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output amge_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data
);

    import amge_pkg::*;

    logic [6:0]            nv_reg;
    mem_req_t              req;
    logic [WeightBits-1:0] rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            nv_reg <= cfg_data;
        end
    end

    amge_matrix u_matrix (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    amge_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .nv        (nv_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data),
        .req       (req),
        .rdata     (rdata)
    );

endmodule

>>> tb/sv/adjacency_matrix_graph_engine_checker.sv
module adjacency_matrix_graph_engine_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  amge_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  amge_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [6:0]          cfg_data,
    output int                  fail_count,
    output int                  pending
);

    import amge_pkg::*;

    logic [WeightBits-1:0] weights [0:Depth-1];
    int unsigned edge_cnt;
    int unsigned vtx_limit;
    out_item_t result_q [$];

    function automatic logic [WeightBits-1:0] weight_at(int unsigned r, int unsigned c);
        return weights[r * MaxVertices + c];
    endfunction

    function automatic bit find_cycle(int unsigned n);
        bit seen [MaxVertices];
        int unsigned fr_vtx [MaxVertices];
        int unsigned fr_par [MaxVertices];
        int unsigned fr_col [MaxVertices];
        int unsigned depth;
        int unsigned t;
        int unsigned v;
        int unsigned w;
        bit found;
        found = 1'b0;
        for (int i = 0; i < MaxVertices; i++)
            seen[i] = 1'b0;
        for (int unsigned root = 0; root < n && !found; root++)
        begin
            if (seen[root])
                continue;
            fr_vtx[0] = root;
            fr_par[0] = root;
            fr_col[0] = 0;
            seen[root] = 1'b1;
            depth = 1;
            while (depth > 0 && !found)
            begin
                t = depth - 1;
                v = fr_vtx[t];
                w = fr_col[t];
                if (w >= n)
                begin
                    depth--;
                    continue;
                end
                fr_col[t] = w + 1;
                if (weight_at(v, w) != 0)
                begin
                    if (!seen[w])
                    begin
                        fr_vtx[depth] = w;
                        fr_par[depth] = v;
                        fr_col[depth] = 0;
                        seen[w] = 1'b1;
                        depth++;
                    end
                    else if (w != fr_par[t])
                        found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    function automatic out_item_t apply_command(in_item_t it);
        out_item_t r;
        int unsigned n;
        int unsigned s;
        int unsigned d;
        bit s_ok;
        bit d_ok;
        r = '0;
        n = (vtx_limit > MaxVertices) ? MaxVertices : vtx_limit;
        s = it.src_vertex;
        d = it.dst_vertex;
        s_ok = s < n;
        d_ok = d < n;
        r.status = ST_DONE;
        case (it.cmd)
            CMD_INSERT:
                if (!s_ok || !d_ok || s == d || it.edge_weight == 0)
                    r.status = ST_INVALID;
                else if (weight_at(s, d) != 0)
                    r.status = ST_UNCHANGED;
                else
                begin
                    weights[s * MaxVertices + d] = it.edge_weight;
                    edge_cnt++;
                end
            CMD_REMOVE:
                if (!s_ok || !d_ok)
                    r.status = ST_INVALID;
                else if (weight_at(s, d) == 0)
                    r.status = ST_UNCHANGED;
                else
                begin
                    weights[s * MaxVertices + d] = '0;
                    edge_cnt--;
                end
            CMD_READ:
                if (!s_ok || !d_ok)
                    r.status = ST_INVALID;
                else
                    r.weight_read = weight_at(s, d);
            CMD_OUTDEG:
                if (!s_ok)
                    r.status = ST_INVALID;
                else
                    for (int unsigned i = 0; i < n; i++)
                        if (weight_at(s, i) != 0)
                            r.degree_count++;
            CMD_INDEG:
                if (!d_ok)
                    r.status = ST_INVALID;
                else
                    for (int unsigned i = 0; i < n; i++)
                        if (weight_at(i, d) != 0)
                            r.degree_count++;
            CMD_CYCLE:
                r.cycle_found = find_cycle(n);
            default:
                r.status = ST_INVALID;
        endcase
        r.edge_total = edge_cnt[EdgeBits-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < Depth; i++)
                weights[i] = '0;
            edge_cnt = 0;
            vtx_limit = MaxVertices;
            result_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.weight_read !== want.weight_read)
                    begin
                        $error("weight_read: expected %0d got %0d",
                               want.weight_read, out_data.weight_read);
                        fail_count++;
                    end
                    if (out_data.degree_count !== want.degree_count)
                    begin
                        $error("degree_count: expected %0d got %0d",
                               want.degree_count, out_data.degree_count);
                        fail_count++;
                    end
                    if (out_data.edge_total !== want.edge_total)
                    begin
                        $error("edge_total: expected %0d got %0d",
                               want.edge_total, out_data.edge_total);
                        fail_count++;
                    end
                    if (out_data.cycle_found !== want.cycle_found)
                    begin
                        $error("cycle_found: expected %0d got %0d",
                               want.cycle_found, out_data.cycle_found);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                vtx_limit = cfg_data;
            if (in_valid && in_ready)
                result_q.push_back(apply_command(in_data));
            pending = result_q.size();
        end
    end

endmodule

>>> tb/sv/adjacency_matrix_graph_engine_core_tb.sv
module adjacency_matrix_graph_engine_core_tb;
    import amge_pkg::*;

    localparam logic [2:0] CmdSpareLo = 3'd6;
    localparam logic [2:0] CmdSpareHi = 3'd7;
    localparam int IdleLimit = 60000;
    localparam int PerPhase = 188;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;
    int         fail_count;
    int         pending;

    int burst_left = 0;
    int sent_total = 0;
    int cycle_cmds = 0;
    int settings_used = 0;
    int idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    adjacency_matrix_graph_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    adjacency_matrix_graph_engine_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // receiver: rotating stall pattern, plus long hold-offs
    int        rx_cycle = 0;
    int        hold_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  pat_idx = '0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (rx_cycle % 700 == 0)
                stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                        : (16'($urandom()) | 16'h1);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_cycle % 40000 == 9000)
            begin
                hold_left = 600;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= stall_pat[pat_idx];
                pat_idx++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout: no beat for %0d cycles", IdleLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_cmd(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        if (it.cmd == CMD_CYCLE)
            cycle_cmds++;
        sent_total++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [2:0] c, input int s, input int d, input int w);
        in_item_t it;
        it.cmd = c;
        it.src_vertex = VtxBits'(s);
        it.dst_vertex = VtxBits'(d);
        it.edge_weight = WeightBits'(w);
        send_cmd(it);
    endtask

    task automatic drain_and_set(input logic [6:0] count);
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_vertex(int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, n - 1);
    endfunction

    function automatic in_item_t random_cmd(int n);
        in_item_t it;
        int r;
        int cyc_pct;
        r = $urandom_range(0, 99);
        cyc_pct = (n > 16) ? 1 : 6;
        it.src_vertex = VtxBits'(pick_vertex(n));
        it.dst_vertex = VtxBits'(pick_vertex(n));
        case ($urandom_range(0, 19))
            0: it.edge_weight = '0;
            1: it.edge_weight = 16'hFFFF;
            default: it.edge_weight = WeightBits'($urandom_range(1, 65535));
        endcase
        if (r < cyc_pct)
            it.cmd = CMD_CYCLE;
        else if (r < 38)
            it.cmd = CMD_INSERT;
        else if (r < 52)
            it.cmd = CMD_REMOVE;
        else if (r < 66)
            it.cmd = CMD_READ;
        else if (r < 80)
            it.cmd = CMD_OUTDEG;
        else if (r < 94)
            it.cmd = CMD_INDEG;
        else if (r < 97)
            it.cmd = CmdSpareLo;
        else
            it.cmd = CmdSpareHi;
        return it;
    endfunction

    int phase_counts [10] = '{0, 1, 2, 5, 127, 8, 16, 64, 3, 64};

    initial
    begin
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        drain_and_set(7'd64);
        send_fields(CMD_READ, 0, 0, 0);
        send_fields(CMD_INSERT, 0, 63, 16'hFFFF);
        send_fields(CMD_INSERT, 63, 0, 1);
        send_fields(CMD_INSERT, 0, 63, 5);
        send_fields(CMD_INSERT, 5, 5, 9);
        send_fields(CMD_INSERT, 2, 3, 0);
        send_fields(CMD_READ, 0, 63, 0);
        send_fields(CMD_READ, 7, 7, 0);
        send_fields(CMD_REMOVE, 7, 7, 0);
        send_fields(CMD_OUTDEG, 0, 0, 0);
        send_fields(CMD_INDEG, 0, 63, 0);
        send_fields(CMD_INDEG, 0, 0, 0);
        // two-vertex back edge to the parent is not a cycle
        send_fields(CMD_CYCLE, 0, 0, 0);
        send_fields(CMD_INSERT, 63, 1, 16'h5555);
        send_fields(CMD_INSERT, 1, 0, 16'hAAAA);
        send_fields(CMD_CYCLE, 63, 63, 16'hFFFF);
        send_fields(CMD_REMOVE, 0, 63, 0);
        send_fields(CMD_REMOVE, 0, 63, 0);
        send_fields(CmdSpareLo, 1, 2, 3);
        send_fields(CmdSpareHi, 63, 63, 16'hFFFF);
        send_fields(CMD_CYCLE, 0, 0, 0);

        foreach (phase_counts[p])
        begin
            drain_and_set(7'(phase_counts[p]));
            n = (phase_counts[p] > MaxVertices) ? MaxVertices : phase_counts[p];
            if (n == 0)
                send_fields(CMD_CYCLE, 0, 0, 0);
            for (int i = 0; i < PerPhase; i++)
                send_cmd(random_cmd(n));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("ran %0d commands (%0d cycle checks) over %0d vertex-count settings",
                 sent_total, cycle_cmds, settings_used);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/amge_pkg.sv
hw/rtl/amge_matrix.sv
hw/rtl/amge_seq.sv
hw/rtl/adjacency_matrix_graph_engine_core.sv
tb/sv/adjacency_matrix_graph_engine_checker.sv
tb/sv/adjacency_matrix_graph_engine_core_tb.sv
